>>> rtl/core/arvu_pkg.sv
// Shared types and constants for the attractor/repeller velocity update block.
// Holds table sizes, controller-to-datapath command and status types.
// No dependencies.
`default_nettype none
package arvu_pkg;

    localparam int MAX_ATTRACTORS = 8;
    localparam int MAX_REPELLERS  = 8;

    localparam int A_IW   = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
    localparam int R_IW   = (MAX_REPELLERS > 1) ? $clog2(MAX_REPELLERS) : 1;
    localparam int MAX_SRC = (MAX_ATTRACTORS > MAX_REPELLERS) ? MAX_ATTRACTORS
                                                               : MAX_REPELLERS;
    localparam int SRC_CW = $clog2(MAX_SRC + 1);

    localparam logic [63:0] TERM_CAP = (64'd1 << 55) - 64'd1;
    localparam logic [33:0] DV_CAP   = 34'd1 << 33;

    localparam logic [1:0] MODE_ATTR  = 2'd0;
    localparam logic [1:0] MODE_REP   = 2'd1;
    localparam logic [1:0] MODE_PART  = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_STORE,
        OP_SRC,
        OP_SQ,
        OP_RT_INIT,
        OP_RT_STEP,
        OP_DEN_LO,
        OP_DEN_HI,
        OP_PROD,
        OP_TDIV_INIT,
        OP_DIV_STEP,
        OP_ACC,
        OP_VDIV_INIT,
        OP_VEL,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              kind;
        logic [SRC_CW-1:0] idx;
        logic [1:0]        axis;
    } t_cmd;

    typedef struct packed {
        logic [SRC_CW-1:0] acnt;
        logic [SRC_CW-1:0] rcnt;
        logic              sqrt_done;
        logic              div_done;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/core/arvu_ctrl.sv
// Sequencer for the velocity update: walks sources, axes and the iterative units.
// Depends on arvu_pkg; drives arvu_dp through t_cmd, reads t_stat.
`default_nettype none
module arvu_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [1:0]     i_mode,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire arvu_pkg::t_stat i_stat,
    output arvu_pkg::t_cmd      o_cmd
);
    import arvu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SRC, S_SQ, S_RTI, S_RT, S_DLO, S_DHI,
        S_PROD, S_TDI, S_TDIV, S_ACC, S_VDI, S_VDIV, S_VEL, S_EMIT
    } t_state;

    t_state            r_state;
    logic              r_kind;
    logic [SRC_CW-1:0] r_idx;
    logic [1:0]        r_axis;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [SRC_CW-1:0] n_idx;
    logic [SRC_CW-1:0] w_cnt;
    logic              w_emit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign n_idx       = r_idx + 1'b1;
    assign w_cnt       = r_kind ? i_stat.rcnt : i_stat.acnt;
    assign w_emit      = !r_out_valid || i_out_ready;
    assign n_out_valid = ((r_state == S_EMIT) && w_emit) || (r_out_valid && !i_out_ready);

    always_comb begin
        o_cmd.kind = r_kind;
        o_cmd.idx  = r_idx;
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LATCH : OP_NOP;
            S_LOAD:  o_cmd.op = OP_STORE;
            S_SRC:   o_cmd.op = OP_SRC;
            S_SQ:    o_cmd.op = OP_SQ;
            S_RTI:   o_cmd.op = OP_RT_INIT;
            S_RT:    o_cmd.op = OP_RT_STEP;
            S_DLO:   o_cmd.op = OP_DEN_LO;
            S_DHI:   o_cmd.op = OP_DEN_HI;
            S_PROD:  o_cmd.op = OP_PROD;
            S_TDI:   o_cmd.op = OP_TDIV_INIT;
            S_TDIV:  o_cmd.op = OP_DIV_STEP;
            S_ACC:   o_cmd.op = OP_ACC;
            S_VDI:   o_cmd.op = OP_VDIV_INIT;
            S_VDIV:  o_cmd.op = OP_DIV_STEP;
            S_VEL:   o_cmd.op = OP_VEL;
            S_EMIT:  o_cmd.op = w_emit ? OP_EMIT : OP_NOP;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= 1'b0;
            r_idx       <= '0;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    r_axis <= 2'd0;
                    r_idx  <= '0;
                    if (i_in_valid) begin
                        if (i_mode == MODE_ATTR || i_mode == MODE_REP) begin
                            r_state <= S_LOAD;
                        end else if (i_mode == MODE_PART) begin
                            if (i_stat.acnt != '0) begin
                                r_kind  <= 1'b0;
                                r_state <= S_SRC;
                            end else if (i_stat.rcnt != '0) begin
                                r_kind  <= 1'b1;
                                r_state <= S_SRC;
                            end else begin
                                r_state <= S_VDI;
                            end
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_LOAD: r_state <= S_EMIT;
                S_SRC: begin
                    r_axis  <= 2'd0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_axis == 2'd2) begin
                        r_axis  <= 2'd0;
                        r_state <= S_RTI;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_RTI: r_state <= S_RT;
                S_RT: begin
                    if (i_stat.sqrt_done) begin
                        r_state <= S_DLO;
                    end
                end
                S_DLO: r_state <= S_DHI;
                S_DHI: r_state <= S_PROD;
                S_PROD: r_state <= S_TDI;
                S_TDI: r_state <= S_TDIV;
                S_TDIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_axis != 2'd2) begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_PROD;
                    end else begin
                        r_axis <= 2'd0;
                        if (n_idx < w_cnt) begin
                            r_idx   <= n_idx;
                            r_state <= S_SRC;
                        end else if (!r_kind && i_stat.rcnt != '0) begin
                            r_kind  <= 1'b1;
                            r_idx   <= '0;
                            r_state <= S_SRC;
                        end else begin
                            r_state <= S_VDI;
                        end
                    end
                end
                S_VDI: r_state <= S_VDIV;
                S_VDIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_VEL;
                    end
                end
                S_VEL: begin
                    if (r_axis == 2'd2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_VDI;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/arvu_dp.sv
// Datapath: source tables, shared multiplier, bit-serial square root and divider.
// Depends on arvu_pkg; obeys t_cmd from arvu_ctrl, reports t_stat.
`default_nettype none
module arvu_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire arvu_pkg::t_cmd      i_cmd,
    output arvu_pkg::t_stat          o_stat,
    input  wire logic [1:0]          i_mode,
    input  wire logic signed [31:0]  i_pos_x,
    input  wire logic signed [31:0]  i_pos_y,
    input  wire logic signed [31:0]  i_pos_z,
    input  wire logic signed [31:0]  i_vel_x,
    input  wire logic signed [31:0]  i_vel_y,
    input  wire logic signed [31:0]  i_vel_z,
    input  wire logic signed [31:0]  i_strength,
    input  wire logic [30:0]         i_mass,
    output logic signed [31:0]       o_new_vel_x,
    output logic signed [31:0]       o_new_vel_y,
    output logic signed [31:0]       o_new_vel_z,
    output logic                     o_table_full,
    output logic                     o_saturated
);
    import arvu_pkg::*;

    logic signed [31:0] r_ax [MAX_ATTRACTORS];
    logic signed [31:0] r_ay [MAX_ATTRACTORS];
    logic signed [31:0] r_az [MAX_ATTRACTORS];
    logic signed [31:0] r_as [MAX_ATTRACTORS];
    logic signed [31:0] r_rx [MAX_REPELLERS];
    logic signed [31:0] r_ry [MAX_REPELLERS];
    logic signed [31:0] r_rz [MAX_REPELLERS];
    logic signed [31:0] r_rs [MAX_REPELLERS];
    logic [SRC_CW-1:0]  r_acnt;
    logic [SRC_CW-1:0]  r_rcnt;

    logic [1:0]         r_mode;
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_str;
    logic [30:0]        r_mass;

    logic [31:0]        r_mag [3];
    logic [2:0]         r_dneg;
    logic [31:0]        r_smag;
    logic               r_sneg;
    logic [63:0]        r_d2;
    logic [63:0]        r_sop;
    logic [63:0]        r_sres;
    logic [63:0]        r_sbit;
    logic [4:0]         r_scnt;
    logic [95:0]        r_den;
    logic [63:0]        r_prod;
    logic [95:0]        r_rem;
    logic [95:0]        r_dden;
    logic [127:0]       r_nsh;
    logic [55:0]        r_q;
    logic [5:0]         r_dcnt;
    logic               r_ovf;
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_res [3];
    logic               r_full;
    logic               r_sat;

    // source fetch and deltas
    logic signed [31:0] w_s [3];
    logic signed [31:0] w_sstr;
    logic signed [32:0] w_d [3];
    logic signed [32:0] w_dm [3];
    always_comb begin
        if (i_cmd.kind) begin
            w_s[0] = r_rx[i_cmd.idx[R_IW-1:0]];
            w_s[1] = r_ry[i_cmd.idx[R_IW-1:0]];
            w_s[2] = r_rz[i_cmd.idx[R_IW-1:0]];
            w_sstr = r_rs[i_cmd.idx[R_IW-1:0]];
        end else begin
            w_s[0] = r_ax[i_cmd.idx[A_IW-1:0]];
            w_s[1] = r_ay[i_cmd.idx[A_IW-1:0]];
            w_s[2] = r_az[i_cmd.idx[A_IW-1:0]];
            w_sstr = r_as[i_cmd.idx[A_IW-1:0]];
        end
        for (int k = 0; k < 3; k++) begin
            w_d[k] = i_cmd.kind ? (33'(r_p[k]) - 33'(w_s[k]))
                                : (33'(w_s[k]) - 33'(r_p[k]));
            w_dm[k] = w_d[k][32] ? -w_d[k] : w_d[k];
        end
    end

    // shared multiplier
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_mp;
    always_comb begin
        case (i_cmd.op)
            OP_SQ: begin
                w_ma = r_mag[i_cmd.axis];
                w_mb = r_mag[i_cmd.axis];
            end
            OP_DEN_LO: begin
                w_ma = r_d2[31:0];
                w_mb = r_sres[31:0];
            end
            OP_DEN_HI: begin
                w_ma = r_d2[63:32];
                w_mb = r_sres[31:0];
            end
            default: begin
                w_ma = r_smag;
                w_mb = r_mag[i_cmd.axis];
            end
        endcase
        w_mp = 64'(w_ma) * 64'(w_mb);
    end

    logic [64:0] w_sqsum;
    assign w_sqsum = {1'b0, r_d2} + {1'b0, w_mp};

    // square root step
    logic [63:0] w_rb;
    assign w_rb = r_sres + r_sbit;

    // divider step and init
    logic [96:0]  w_t;
    logic         w_ge;
    logic [96:0]  w_tsub;
    logic [127:0] w_tnum;
    logic [63:0]  w_amag;
    logic [127:0] w_vnum;
    logic [95:0]  w_vden;
    assign w_t    = {r_rem, r_nsh[127]};
    assign w_ge   = w_t >= {1'b0, r_dden};
    assign w_tsub = w_t - {1'b0, r_dden};
    assign w_tnum = {32'd0, r_prod, 32'd0};
    assign w_amag = r_acc[i_cmd.axis][63] ? 64'(-r_acc[i_cmd.axis])
                                          : 64'(r_acc[i_cmd.axis]);
    assign w_vnum = {48'd0, w_amag, 16'd0};
    assign w_vden = {65'd0, (r_mass == 31'd0) ? 31'd1 : r_mass};

    // accumulate and velocity
    logic [63:0]        w_f;
    logic               w_tneg;
    logic [33:0]        w_dv;
    logic signed [35:0] w_vsum;
    assign w_f    = r_ovf ? TERM_CAP : 64'(r_q[55:0]);
    assign w_tneg = r_sneg ^ r_dneg[i_cmd.axis];
    assign w_dv   = (r_ovf || r_q[33:0] > DV_CAP) ? DV_CAP : r_q[33:0];
    assign w_vsum = 36'(r_v[i_cmd.axis])
                  + (r_acc[i_cmd.axis][63] ? -36'(w_dv) : 36'(w_dv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acnt <= '0;
            r_rcnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_LATCH: begin
                    r_mode <= i_mode;
                    r_p[0] <= i_pos_x;
                    r_p[1] <= i_pos_y;
                    r_p[2] <= i_pos_z;
                    r_v[0] <= i_vel_x;
                    r_v[1] <= i_vel_y;
                    r_v[2] <= i_vel_z;
                    r_str  <= i_strength;
                    r_mass <= i_mass;
                    r_full <= 1'b0;
                    r_sat  <= 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= '0;
                        r_res[k] <= '0;
                    end
                end
                OP_STORE: begin
                    if (r_mode == MODE_ATTR) begin
                        if (r_acnt < SRC_CW'(MAX_ATTRACTORS)) begin
                            r_ax[r_acnt[A_IW-1:0]] <= r_p[0];
                            r_ay[r_acnt[A_IW-1:0]] <= r_p[1];
                            r_az[r_acnt[A_IW-1:0]] <= r_p[2];
                            r_as[r_acnt[A_IW-1:0]] <= r_str;
                            r_acnt <= r_acnt + 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end else begin
                        if (r_rcnt < SRC_CW'(MAX_REPELLERS)) begin
                            r_rx[r_rcnt[R_IW-1:0]] <= r_p[0];
                            r_ry[r_rcnt[R_IW-1:0]] <= r_p[1];
                            r_rz[r_rcnt[R_IW-1:0]] <= r_p[2];
                            r_rs[r_rcnt[R_IW-1:0]] <= r_str;
                            r_rcnt <= r_rcnt + 1'b1;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                end
                OP_SRC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k]  <= w_dm[k][31:0];
                        r_dneg[k] <= w_d[k][32];
                    end
                    r_smag <= w_sstr[31] ? 32'(-33'(w_sstr)) : 32'(w_sstr);
                    r_sneg <= w_sstr[31];
                    r_d2   <= 64'd1;
                end
                OP_SQ: begin
                    r_d2 <= w_sqsum[64] ? '1 : w_sqsum[63:0];
                end
                OP_RT_INIT: begin
                    r_sop  <= r_d2;
                    r_sres <= '0;
                    r_sbit <= 64'd1 << 62;
                    r_scnt <= 5'd31;
                end
                OP_RT_STEP: begin
                    if (r_sop >= w_rb) begin
                        r_sop  <= r_sop - w_rb;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_scnt <= r_scnt - 5'd1;
                end
                OP_DEN_LO: r_den <= 96'(w_mp);
                OP_DEN_HI: r_den <= r_den + {w_mp, 32'd0};
                OP_PROD:   r_prod <= w_mp;
                OP_TDIV_INIT: begin
                    r_ovf  <= {23'd0, w_tnum[127:55]} >= r_den;
                    r_rem  <= {23'd0, w_tnum[127:55]};
                    r_nsh  <= {w_tnum[54:0], 73'd0};
                    r_dden <= r_den;
                    r_dcnt <= 6'd54;
                    r_q    <= '0;
                end
                OP_VDIV_INIT: begin
                    r_ovf  <= {2'd0, w_vnum[127:34]} >= w_vden;
                    r_rem  <= {2'd0, w_vnum[127:34]};
                    r_nsh  <= {w_vnum[33:0], 94'd0};
                    r_dden <= w_vden;
                    r_dcnt <= 6'd33;
                    r_q    <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem  <= w_ge ? w_tsub[95:0] : w_t[95:0];
                    r_q    <= {r_q[54:0], w_ge};
                    r_nsh  <= {r_nsh[126:0], 1'b0};
                    r_dcnt <= r_dcnt - 6'd1;
                end
                OP_ACC: begin
                    r_acc[i_cmd.axis] <= w_tneg ? (r_acc[i_cmd.axis] - $signed(w_f))
                                                : (r_acc[i_cmd.axis] + $signed(w_f));
                end
                OP_VEL: begin
                    if (w_vsum > 36'sh0_7FFF_FFFF) begin
                        r_res[i_cmd.axis] <= 32'sh7FFF_FFFF;
                        r_sat <= 1'b1;
                    end else if (w_vsum < -36'sh0_8000_0000) begin
                        r_res[i_cmd.axis] <= 32'sh8000_0000;
                        r_sat <= 1'b1;
                    end else begin
                        r_res[i_cmd.axis] <= w_vsum[31:0];
                    end
                end
                OP_EMIT: begin
                    o_new_vel_x  <= r_res[0];
                    o_new_vel_y  <= r_res[1];
                    o_new_vel_z  <= r_res[2];
                    o_table_full <= r_full;
                    o_saturated  <= r_sat;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.acnt      = r_acnt;
    assign o_stat.rcnt      = r_rcnt;
    assign o_stat.sqrt_done = (r_scnt == 5'd0);
    assign o_stat.div_done  = (r_dcnt == 6'd0);

endmodule
`default_nettype wire

>>> rtl/core/attractor_repeller_velocity_update.sv
// Top level of the attractor/repeller velocity update block.
// Joins arvu_ctrl (sequencer) and arvu_dp (tables and arithmetic); uses arvu_pkg.
//
//   channel | signals                      | payload
//   in      | i_in_valid / o_in_ready      | i_mode, i_pos_*, i_vel_*, i_strength, i_mass
//   out     | o_out_valid / i_out_ready    | o_new_vel_*, o_table_full, o_saturated
//
// Loads pass through S_LOAD to S_EMIT; no-op items go straight to S_EMIT. A particle's
// time grows with the N stored sources and is set by the one-bit-per-cycle divider
// (55 steps per axis term, 34 per velocity axis) and the 32-step square root.
// Reset empties both tables. A result waits in the output register while the next
// item is taken; a stalled output holds the sequencer before its next transfer.
`default_nettype none
module attractor_repeller_velocity_update (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic signed [31:0] i_vel_z,
    input  wire logic signed [31:0] i_strength,
    input  wire logic [30:0]        i_mass,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y,
    output logic signed [31:0]      o_new_vel_z,
    output logic                    o_table_full,
    output logic                    o_saturated
);
    import arvu_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    arvu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    arvu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_mode       (i_mode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .i_strength   (i_strength),
        .i_mass       (i_mass),
        .o_new_vel_x  (o_new_vel_x),
        .o_new_vel_y  (o_new_vel_y),
        .o_new_vel_z  (o_new_vel_z),
        .o_table_full (o_table_full),
        .o_saturated  (o_saturated)
    );

endmodule
`default_nettype wire

>>> tb/sv/attractor_repeller_velocity_update_tb.sv
// Self-checking testbench for attractor_repeller_velocity_update: directed and random
// source loads and particle updates, with a scoreboard that predicts every result.
// Depends on arvu_pkg and the block's RTL.
`default_nettype none
module attractor_repeller_velocity_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arvu_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 750;
    localparam int CALM_ITEMS = 100;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] pos[3];
        logic signed [31:0] vel[3];
        logic signed [31:0] strength;
        logic [30:0]        mass;
    } t_item;

    typedef struct {
        logic signed [31:0] vel[3];
        logic               full;
        logic               sat;
    } t_result;

    typedef struct {
        logic signed [31:0] pos[3];
        logic signed [31:0] strength;
    } t_source;

    class arvu_scoreboard;
        t_source attr[MAX_ATTRACTORS];
        t_source rep[MAX_REPELLERS];
        int      attr_cnt;
        int      rep_cnt;
        t_result pending_q[$];
        int      errors;
        int      checked;

        function new();
            attr_cnt = 0;
            rep_cnt = 0;
            errors = 0;
            checked = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function automatic logic [63:0] root64(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] t;
            res = 0;
            for (int i = 31; i >= 0; i--) begin
                t = res | (64'd1 << i);
                if (t * t <= v) res = t;
            end
            return res;
        endfunction

        function automatic void add_force(longint d[3], logic signed [31:0] str,
                                          ref longint acc[3]);
            logic [64:0]  s;
            logic [63:0]  m;
            logic [63:0]  d2;
            logic [63:0]  r;
            logic [63:0]  smag;
            logic [127:0] den;
            logic [127:0] num;
            logic [127:0] q;
            s = 65'd1;
            for (int k = 0; k < 3; k++) begin
                m = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
                s = s + 65'(m * m);
                if (s[64]) s = {1'b0, {64{1'b1}}};
            end
            d2 = s[63:0];
            r = root64(d2);
            den = {64'd0, d2} * {64'd0, r};
            smag = (str < 0) ? 64'(-longint'(str)) : 64'(longint'(str));
            for (int k = 0; k < 3; k++) begin
                m = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
                num = {64'd0, smag * m} << 32;
                q = num / den;
                if (q > 128'(TERM_CAP)) q = 128'(TERM_CAP);
                if ((str < 0) != (d[k] < 0)) acc[k] -= longint'(q[63:0]);
                else acc[k] += longint'(q[63:0]);
            end
        endfunction

        function automatic void note_input(t_item it);
            t_result res;
            longint  acc[3];
            longint  d[3];
            longint  v;
            logic [63:0]  am;
            logic [127:0] q;
            logic [30:0]  mass;
            res.vel = '{0, 0, 0};
            res.full = 0;
            res.sat = 0;
            acc = '{0, 0, 0};
            if (it.mode == MODE_ATTR) begin
                if (attr_cnt >= MAX_ATTRACTORS) res.full = 1;
                else begin
                    attr[attr_cnt].pos = it.pos;
                    attr[attr_cnt].strength = it.strength;
                    attr_cnt++;
                end
            end else if (it.mode == MODE_REP) begin
                if (rep_cnt >= MAX_REPELLERS) res.full = 1;
                else begin
                    rep[rep_cnt].pos = it.pos;
                    rep[rep_cnt].strength = it.strength;
                    rep_cnt++;
                end
            end else if (it.mode == MODE_PART) begin
                for (int i = 0; i < attr_cnt; i++) begin
                    for (int k = 0; k < 3; k++)
                        d[k] = longint'(attr[i].pos[k]) - longint'(it.pos[k]);
                    add_force(d, attr[i].strength, acc);
                end
                for (int i = 0; i < rep_cnt; i++) begin
                    for (int k = 0; k < 3; k++)
                        d[k] = longint'(it.pos[k]) - longint'(rep[i].pos[k]);
                    add_force(d, rep[i].strength, acc);
                end
                mass = (it.mass == 0) ? 31'd1 : it.mass;
                for (int k = 0; k < 3; k++) begin
                    am = (acc[k] < 0) ? 64'(-acc[k]) : 64'(acc[k]);
                    q = ({64'd0, am} << 16) / {97'd0, mass};
                    if (q > 128'(DV_CAP)) q = 128'(DV_CAP);
                    v = longint'(it.vel[k]);
                    if (acc[k] < 0) v -= longint'(q[63:0]);
                    else v += longint'(q[63:0]);
                    if (v > 64'sh7FFFFFFF) begin
                        v = 64'sh7FFFFFFF;
                        res.sat = 1;
                    end
                    if (v < -64'sh80000000) begin
                        v = -64'sh80000000;
                        res.sat = 1;
                    end
                    res.vel[k] = v[31:0];
                end
            end
            pending_q.insert(pending_q.size(), res);
        endfunction

        task check_result(t_result act);
            t_result exp_r;
            checked++;
            if (pending_q.size() == 0) begin
                report("result transfer with nothing pending");
            end else begin
                exp_r = pending_q.pop_front();
                for (int k = 0; k < 3; k++)
                    if (act.vel[k] !== exp_r.vel[k])
                        report($sformatf("new_vel[%0d] got %h want %h",
                                         k, act.vel[k], exp_r.vel[k]));
                if (act.full !== exp_r.full)
                    report($sformatf("table_full got %b want %b", act.full, exp_r.full));
                if (act.sat !== exp_r.sat)
                    report($sformatf("saturated got %b want %b", act.sat, exp_r.sat));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_mode;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_vel_x, i_vel_y, i_vel_z;
    logic signed [31:0] i_strength;
    logic [30:0]        i_mass;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic               o_table_full;
    logic               o_saturated;

    arvu_scoreboard sb;
    bit  idle_en;
    int  stall_left;
    int  quiet_cycles;
    int  sent;

    attractor_repeller_velocity_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y), .i_vel_z(i_vel_z),
        .i_strength(i_strength), .i_mass(i_mass),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_new_vel_x(o_new_vel_x), .o_new_vel_y(o_new_vel_y), .o_new_vel_z(o_new_vel_z),
        .o_table_full(o_table_full), .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result act;
        if (o_out_valid && i_out_ready) begin
            act.vel = '{o_new_vel_x, o_new_vel_y, o_new_vel_z};
            act.full = o_table_full;
            act.sat = o_saturated;
            sb.check_result(act);
        end
        if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    sel;
        sel = $urandom_range(0, 19);
        if (sel < 5) it.mode = MODE_ATTR;
        else if (sel < 10) it.mode = MODE_REP;
        else if (sel < 19) it.mode = MODE_PART;
        else it.mode = MODE_NOP;
        for (int k = 0; k < 3; k++) begin
            it.pos[k] = rand_word();
            it.vel[k] = rand_word();
        end
        it.strength = rand_word();
        case ($urandom_range(0, 4))
            0: it.mass = 31'd0;
            1: it.mass = 31'h7FFFFFFF;
            2: it.mass = 31'($urandom_range(1, 255));
            default: it.mass = 31'($urandom());
        endcase
        return it;
    endfunction

    function automatic t_item make_item(logic [1:0] mode, logic signed [31:0] px,
                                        logic signed [31:0] py, logic signed [31:0] pz,
                                        logic signed [31:0] v, logic signed [31:0] str,
                                        logic [30:0] mass);
        t_item it;
        it.mode = mode;
        it.pos = '{px, py, pz};
        it.vel = '{v, -v, v};
        it.strength = str;
        it.mass = mass;
        return it;
    endfunction

    task send(t_item it);
        int gap;
        gap = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode <= it.mode;
        i_pos_x <= it.pos[0];
        i_pos_y <= it.pos[1];
        i_pos_z <= it.pos[2];
        i_vel_x <= it.vel[0];
        i_vel_y <= it.vel[1];
        i_vel_z <= it.vel[2];
        i_strength <= it.strength;
        i_mass <= it.mass;
        i_in_valid <= 1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_input(it);
        sent++;
    endtask

    task drain();
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        idle_en = 1;
        stall_left = 0;
        quiet_cycles = 0;
        sent = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_mode = MODE_NOP;
        i_pos_x = 0;
        i_pos_y = 0;
        i_pos_z = 0;
        i_vel_x = 0;
        i_vel_y = 0;
        i_vel_z = 0;
        i_strength = 0;
        i_mass = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(make_item(MODE_PART, 32'sh7FFFFFFF, 32'sh80000000, 0,
                       32'sh7FFFFFFF, 0, 31'd0));
        send(make_item(MODE_NOP, -1, -1, -1, -1, -1, 31'h7FFFFFFF));
        send(make_item(MODE_ATTR, 32'sh00010000, 0, 0, 0, 32'sh7FFFFFFF, 31'd1));
        send(make_item(MODE_ATTR, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                       0, 32'sh80000000, 31'd1));
        send(make_item(MODE_REP, 0, 32'sh00020000, 0, 0, 32'sh00400000, 31'd1));
        send(make_item(MODE_REP, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                       0, 32'shFFFF0000, 31'd1));
        send(make_item(MODE_PART, 0, 0, 0, 0, 0, 31'h00010000));
        send(make_item(MODE_PART, 32'sh00010000, 0, 0, 32'sh7FFFFFF0, 0, 31'd0));
        send(make_item(MODE_PART, 32'sh00010000, 0, 0, 32'sh80000010, 0, 31'd1));
        send(make_item(MODE_PART, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh80000000, 0, 31'h7FFFFFFF));
        send(make_item(MODE_PART, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                       32'sh12345678, 0, 31'h00000100));
        for (int i = 0; i < 7; i++)
            send(make_item(MODE_ATTR, i << 18, -(i << 17), i << 16, 0,
                           32'sh00010000 << i, 31'd1));
        for (int i = 0; i < 7; i++)
            send(make_item(MODE_REP, -(i << 18), i << 17, 32'sh00300000, 0,
                           -(32'sh00008000 << i), 31'd1));
        send(make_item(MODE_PART, 32'sh00050000, 32'shFFFD0000, 32'sh00020000,
                       32'sh00001000, 0, 31'h00000800));

        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) idle_en = 0;
            send(rand_item());
        end

        drain();
        $display("Covered %0d input transfers and %0d checked results, loads into full",
                 sent, sb.checked);
        $display("and partial tables, particle updates with saturation, and random stalls");
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/core/arvu_pkg.sv
rtl/core/arvu_ctrl.sv
rtl/core/arvu_dp.sv
rtl/core/attractor_repeller_velocity_update.sv
tb/sv/attractor_repeller_velocity_update_tb.sv
